>>> src/plsw_pkg.sv
// ----------------------------------------------------------------------------
// plsw_pkg
// shared constants and types of the packed life stencil step block
// ----------------------------------------------------------------------------
`default_nettype none

package plsw_pkg;

   localparam int WORD_W            = 64;
   localparam int CFG_W             = 7;
   localparam int COL_OUT_W         = 6;
   localparam int ROW_CNT_W         = 2;
   localparam int NIB_W             = 4;
   localparam int EDGE_SHIFT        = 60;
   localparam int MAX_ROW_WORDS_DEF = 64;

   localparam logic [WORD_W-1:0]    NIBBLE_ONES = 64'h1111_1111_1111_1111;
   localparam logic [ROW_CNT_W-1:0] ROW_FULL    = 2'd2;

   typedef logic [WORD_W-1:0] word_type;

   // operand words of one lane: three rows of the center column and the three words of each side column
   typedef struct packed {
      word_type top;
      word_type mid;
      word_type bot;
      word_type lft0;
      word_type lft1;
      word_type lft2;
      word_type rgt0;
      word_type rgt1;
      word_type rgt2;
   } lane_ops_type;

   typedef struct packed {
      logic has0;
      logic has1;
   } res_flags_type;

   typedef struct packed {
      logic load2;
      logic load3;
      logic load4;
   } pipe_ctl_type;

   typedef struct packed {
      logic v1;
      logic v2;
   } front_stat_type;

   typedef struct packed {
      logic v3;
      logic free4;
   } merge_stat_type;

endpackage

`default_nettype wire

>>> src/plsw_if.sv
// ----------------------------------------------------------------------------
// plsw channel interfaces
// valid/ready channels for grid words in and next-generation words out
// ----------------------------------------------------------------------------
`default_nettype none

interface plsw_req_if import plsw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   cell_word;
   logic                frame_start;

   modport source (output valid, output cell_word, output frame_start, input ready);
   modport sink   (input valid, input cell_word, input frame_start, output ready);
endinterface

interface plsw_rsp_if import plsw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    next_word;
   logic [COL_OUT_W-1:0] out_column;
   logic                 run_last;

   modport source (output valid, output next_word, output out_column, output run_last,
                   input ready);
   modport sink   (input valid, input next_word, input out_column, input run_last,
                   output ready);
endinterface

`default_nettype wire

>>> src/packed_life_stencil_step_top.sv
// ----------------------------------------------------------------------------
// packed_life_stencil_step_top
// one life generation over a padded grid streamed as 64-bit words of 16 cells
// ----------------------------------------------------------------------------
// req_ch carries grid words in raster order; frame_start marks word 0 of a grid.
// csr_wr_en/csr_wr_data set the row width in words; write only while idle.
// rsp_ch carries next-generation words of rows 1 onward, one column behind the
// input; the last word of a row over one word wide yields two results, and
// run_last marks the final one. Each result passes the line store read, the
// operand stage and the count sums, then the rule into the output register.
// Throughput: one word per cycle while rsp_ch takes results; a word that ends a
// row from row 2 on and yields two results holds the response side for both.
// When rsp_ch stalls, the 4-stage pipeline keeps taking words until its empty
// stages are filled, then drops req_ch.ready; nothing is lost.
// Reset clears counters, window and valid bits and sets the width to 1; the
// line stores are not cleared, the row gating never uses an unwritten entry.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_life_stencil_step_top import plsw_pkg::*; #(
   parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   plsw_req_if.sink              req_ch,
   plsw_rsp_if.source            rsp_ch,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   localparam int COL_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;

   pipe_ctl_type   ctl;
   front_stat_type fstat;
   merge_stat_type mstat;
   lane_ops_type   ops0, ops1;
   res_flags_type  flags2;
   logic [COL_W-1:0] col2;
   word_type       res0, res1;
   logic           free2, free3, accept;

   always_comb begin
      ctl.load4    = mstat.v3 && mstat.free4;
      free3        = !mstat.v3 || ctl.load4;
      ctl.load3    = fstat.v2 && free3;
      free2        = !fstat.v2 || ctl.load3;
      ctl.load2    = fstat.v1 && free2;
      req_ch.ready = !fstat.v1 || ctl.load2;
   end

   assign accept = req_ch.valid && req_ch.ready;

   plsw_front #(.MAX_ROW_WORDS(MAX_ROW_WORDS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .cell_word   (req_ch.cell_word),
      .frame_start (req_ch.frame_start),
      .ctl         (ctl),
      .stat        (fstat),
      .ops0        (ops0),
      .ops1        (ops1),
      .flags2      (flags2),
      .col2        (col2)
   );

   plsw_lane u_lane0 (
      .clock  (clock),
      .en_sum (ctl.load3),
      .en_res (ctl.load4),
      .ops    (ops0),
      .result (res0)
   );

   plsw_lane u_lane1 (
      .clock  (clock),
      .en_sum (ctl.load3),
      .en_res (ctl.load4),
      .ops    (ops1),
      .result (res1)
   );

   plsw_merge #(.MAX_ROW_WORDS(MAX_ROW_WORDS)) u_merge (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .flags2 (flags2),
      .col2   (col2),
      .res0   (res0),
      .res1   (res1),
      .stat   (mstat),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

>>> src/plsw_front.sv
// ----------------------------------------------------------------------------
// plsw_front
// position counters, two line stores, 3x3 word window and lane operand stage
// ----------------------------------------------------------------------------
`default_nettype none

module plsw_front import plsw_pkg::*; #(
   parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF,
   localparam int COL_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [CFG_W-1:0]  csr_wr_data,
   input  wire logic              accept,
   input  wire logic [WORD_W-1:0] cell_word,
   input  wire logic              frame_start,
   input  wire pipe_ctl_type      ctl,
   output front_stat_type         stat,
   output lane_ops_type           ops0,
   output lane_ops_type           ops1,
   output res_flags_type          flags2,
   output logic [COL_W-1:0]       col2
);

   localparam int LW = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

   typedef struct packed {
      logic has0;
      logic has1;
      logic hasl0;
      logic hasr0;
      logic hasl1;
   } s1_flags_type;

   logic [CFG_W-1:0]     row_words_ff;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;

   logic [COL_W-1:0]     c;
   logic [ROW_CNT_W-1:0] r;
   logic [LW-1:0]        c_ext, cfg_ext, max_ext, rw_eff;
   logic                 last;
   s1_flags_type         f_new;

   logic [WORD_W-1:0]    older_mem  [MAX_ROW_WORDS];
   logic [WORD_W-1:0]    middle_mem [MAX_ROW_WORDS];

   logic                 v1_ff, v2_ff;
   logic [WORD_W-1:0]    s1_b_ff, rd_t_ff, rd_m_ff;
   logic [COL_W-1:0]     s1_c_ff;
   s1_flags_type         s1_f_ff;
   logic                 fwd;

   logic [WORD_W-1:0]    w_ff [6];
   lane_ops_type         ops0_ff, ops1_ff, ops0_in, ops1_in;
   res_flags_type        flags2_ff;
   logic [COL_W-1:0]     col2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_words_ff <= CFG_W'(1);
      end else if (csr_wr_en) begin
         row_words_ff <= csr_wr_data;
      end
   end

   // position of the incoming word
   always_comb begin
      c       = frame_start ? '0 : col_ff;
      r       = frame_start ? '0 : row_ff;
      c_ext   = LW'(c);
      cfg_ext = LW'(row_words_ff);
      max_ext = LW'(MAX_ROW_WORDS);
      if (cfg_ext == '0) begin
         rw_eff = LW'(1);
      end else if (cfg_ext > max_ext) begin
         rw_eff = max_ext;
      end else begin
         rw_eff = cfg_ext;
      end
      last    = (c_ext + LW'(1)) >= rw_eff;
      f_new.has0  = (r == ROW_FULL) && (c_ext >= LW'(1));
      f_new.has1  = (r == ROW_FULL) && last;
      f_new.hasl0 = c_ext >= LW'(2);
      f_new.hasr0 = c_ext < rw_eff;
      f_new.hasl1 = c_ext >= LW'(1);
      if (last) begin
         col_in = '0;
         row_in = (r < ROW_FULL) ? r + ROW_CNT_W'(1) : r;
      end else begin
         col_in = c + COL_W'(1);
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores, with bypass of the write that lands in the same cycle
   assign fwd = ctl.load2 && (s1_c_ff == c);

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         older_mem[s1_c_ff]  <= rd_m_ff;
         middle_mem[s1_c_ff] <= s1_b_ff;
      end
      if (accept) begin
         if (fwd) begin
            rd_t_ff <= rd_m_ff;
            rd_m_ff <= s1_b_ff;
         end else begin
            rd_t_ff <= older_mem[c];
            rd_m_ff <= middle_mem[c];
         end
         s1_b_ff <= cell_word;
         s1_c_ff <= c;
         s1_f_ff <= f_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (accept) begin
            v1_ff <= 1'b1;
         end else if (ctl.load2) begin
            v1_ff <= 1'b0;
         end
         if (ctl.load2) begin
            v2_ff <= 1'b1;
         end else if (ctl.load3) begin
            v2_ff <= 1'b0;
         end
      end
   end

   // lane operands from the window before it shifts
   always_comb begin
      ops0_in.top  = w_ff[0];
      ops0_in.mid  = w_ff[1];
      ops0_in.bot  = w_ff[2];
      ops0_in.lft0 = s1_f_ff.hasl0 ? w_ff[3] : '0;
      ops0_in.lft1 = s1_f_ff.hasl0 ? w_ff[4] : '0;
      ops0_in.lft2 = s1_f_ff.hasl0 ? w_ff[5] : '0;
      ops0_in.rgt0 = s1_f_ff.hasr0 ? rd_t_ff : '0;
      ops0_in.rgt1 = s1_f_ff.hasr0 ? rd_m_ff : '0;
      ops0_in.rgt2 = s1_f_ff.hasr0 ? s1_b_ff : '0;
      ops1_in.top  = rd_t_ff;
      ops1_in.mid  = rd_m_ff;
      ops1_in.bot  = s1_b_ff;
      ops1_in.lft0 = s1_f_ff.hasl1 ? w_ff[0] : '0;
      ops1_in.lft1 = s1_f_ff.hasl1 ? w_ff[1] : '0;
      ops1_in.lft2 = s1_f_ff.hasl1 ? w_ff[2] : '0;
      ops1_in.rgt0 = '0;
      ops1_in.rgt1 = '0;
      ops1_in.rgt2 = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            w_ff[i] <= '0;
         end
      end else if (ctl.load2) begin
         w_ff[3] <= w_ff[0];
         w_ff[4] <= w_ff[1];
         w_ff[5] <= w_ff[2];
         w_ff[0] <= rd_t_ff;
         w_ff[1] <= rd_m_ff;
         w_ff[2] <= s1_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         ops0_ff        <= ops0_in;
         ops1_ff        <= ops1_in;
         flags2_ff.has0 <= s1_f_ff.has0;
         flags2_ff.has1 <= s1_f_ff.has1;
         col2_ff        <= s1_c_ff;
      end
   end

   assign stat.v1 = v1_ff;
   assign stat.v2 = v2_ff;
   assign ops0    = ops0_ff;
   assign ops1    = ops1_ff;
   assign flags2  = flags2_ff;
   assign col2    = col2_ff;

endmodule

`default_nettype wire

>>> src/plsw_lane.sv
// ----------------------------------------------------------------------------
// plsw_lane
// two-stage next-generation word: neighbor count sums, then the SWAR rule
// ----------------------------------------------------------------------------
`default_nettype none

module plsw_lane import plsw_pkg::*; (
   input  wire logic         clock,
   input  wire logic         en_sum,
   input  wire logic         en_res,
   input  wire lane_ops_type ops,
   output word_type          result
);

   word_type rows_ff, rows_in;
   word_type mids_ff, mids_in;
   word_type side_ff, side_in;
   word_type m_ff;
   word_type res_ff, res_in;
   word_type lsum, rsum, cnt, comb;

   always_comb begin
      rows_in = (ops.top << NIB_W) + ops.top + (ops.top >> NIB_W)
              + (ops.bot << NIB_W) + ops.bot + (ops.bot >> NIB_W);
      mids_in = (ops.mid << NIB_W) + (ops.mid >> NIB_W);
      lsum    = ops.lft0 + ops.lft1 + ops.lft2;
      rsum    = ops.rgt0 + ops.rgt1 + ops.rgt2;
      side_in = (lsum << EDGE_SHIFT) + (rsum >> EDGE_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en_sum) begin
         rows_ff <= rows_in;
         mids_ff <= mids_in;
         side_ff <= side_in;
         m_ff    <= ops.mid;
      end
   end

   always_comb begin
      cnt    = rows_ff + mids_ff + side_ff;
      comb   = m_ff | cnt;
      res_in = (comb & (comb >> 1)) & ~((comb >> 2) | (comb >> 3)) & NIBBLE_ONES;
   end

   always_ff @(posedge clock) begin
      if (en_res) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

>>> src/plsw_merge.sv
// ----------------------------------------------------------------------------
// plsw_merge
// orders the results of both lanes onto the response channel
// ----------------------------------------------------------------------------
`default_nettype none

module plsw_merge import plsw_pkg::*; #(
   parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF,
   localparam int COL_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pipe_ctl_type  ctl,
   input  wire res_flags_type flags2,
   input  wire logic [COL_W-1:0] col2,
   input  wire word_type      res0,
   input  wire word_type      res1,
   output merge_stat_type     stat,
   plsw_rsp_if.source         rsp_ch
);

   localparam int CWX = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;

   logic                 v3_ff;
   res_flags_type        flags3_ff;
   logic [COL_W-1:0]     col3_ff, col4_ff;
   logic                 pend0_ff, pend1_ff;
   logic [CWX-1:0]       col_x;
   logic [COL_OUT_W-1:0] col6;
   logic                 xfer;

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         flags3_ff <= flags2;
         col3_ff   <= col2;
      end
      if (ctl.load4) begin
         col4_ff <= col3_ff;
      end
   end

   assign xfer = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff    <= 1'b0;
         pend0_ff <= 1'b0;
         pend1_ff <= 1'b0;
      end else begin
         if (ctl.load3) begin
            v3_ff <= 1'b1;
         end else if (ctl.load4) begin
            v3_ff <= 1'b0;
         end
         if (ctl.load4) begin
            pend0_ff <= flags3_ff.has0;
            pend1_ff <= flags3_ff.has1;
         end else if (xfer) begin
            if (pend0_ff) begin
               pend0_ff <= 1'b0;
            end else begin
               pend1_ff <= 1'b0;
            end
         end
      end
   end

   assign col_x = CWX'(col4_ff);
   assign col6  = col_x[COL_OUT_W-1:0];

   assign stat.v3    = v3_ff;
   assign stat.free4 = !(pend0_ff || pend1_ff) || (rsp_ch.ready && (pend0_ff != pend1_ff));

   assign rsp_ch.valid      = pend0_ff || pend1_ff;
   assign rsp_ch.next_word  = pend0_ff ? res0 : res1;
   assign rsp_ch.out_column = pend0_ff ? col6 - COL_OUT_W'(1) : col6;
   assign rsp_ch.run_last   = pend0_ff ? !pend1_ff : 1'b1;

endmodule

`default_nettype wire

>>> tb/sv/packed_life_stencil_step_top_tb.sv
// ----------------------------------------------------------------------------
// packed_life_stencil_step_top_tb
// self-checking bench for one life generation over streamed grid words
// ----------------------------------------------------------------------------
// Streams padded grids of many row widths, including width 0 and widths past
// the line store depth, with random and sparse cell words and random gaps on
// both channels. A scoreboard keeps its own line stores, word window and
// row/column counters. It predicts every next-generation word and checks the
// results in order, field by field.
// ----------------------------------------------------------------------------
module packed_life_stencil_step_top_tb;
   import plsw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WORDS     = MAX_ROW_WORDS_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int TOTAL_WORDS   = 1670;

   typedef struct {
      word_type             next_word;
      logic [COL_OUT_W-1:0] out_column;
      logic                 run_last;
   } next_gen_type;

   class life_step_scoreboard;
      logic [CFG_W-1:0] row_words;
      word_type         older_line[MAX_WORDS];
      word_type         middle_line[MAX_WORDS];
      word_type         window[6];
      int unsigned      column_count;
      int unsigned      row_count;
      next_gen_type     pending_words[$];
      int               errors;

      function new();
         row_words    = 1;
         column_count = 0;
         row_count    = 0;
         errors       = 0;
         foreach (older_line[i]) older_line[i] = '0;
         foreach (middle_line[i]) middle_line[i] = '0;
         foreach (window[i]) window[i] = '0;
      endfunction

      function word_type life_rule_word(input word_type t, input word_type m,
                                        input word_type b, input word_type lsum,
                                        input bit has_l, input word_type rsum,
                                        input bit has_r);
         word_type cnt;
         word_type comb;
         cnt = (t << NIB_W) + t + (t >> NIB_W) + (b << NIB_W) + b + (b >> NIB_W)
             + (m << NIB_W) + (m >> NIB_W);
         if (has_l) cnt = cnt + (lsum << EDGE_SHIFT);
         if (has_r) cnt = cnt + (rsum >> EDGE_SHIFT);
         comb = m | cnt;
         return comb & (comb >> 1) & ~((comb >> 2) | (comb >> 3)) & NIBBLE_ONES;
      endfunction

      function void take_cell_word(input word_type grid_word, input logic frame_start);
         int unsigned  rw;
         int unsigned  c;
         bit           last;
         word_type     t;
         word_type     m;
         word_type     b;
         next_gen_type r;
         rw = (row_words == 0) ? 1 : ((row_words > MAX_WORDS) ? MAX_WORDS : row_words);
         if (frame_start) begin
            column_count = 0;
            row_count    = 0;
         end
         c    = (column_count >= MAX_WORDS) ? MAX_WORDS - 1 : column_count;
         last = (c + 1 >= rw);
         t    = older_line[c];
         m    = middle_line[c];
         b    = grid_word;
         if (row_count >= 2) begin
            if (c >= 1) begin
               r.next_word  = life_rule_word(window[0], window[1], window[2],
                                             window[3] + window[4] + window[5], c > 1,
                                             t + m + b, c < rw);
               r.out_column = COL_OUT_W'(c - 1);
               r.run_last   = !last;
               pending_words = {pending_words, r};
            end
            if (last) begin
               r.next_word  = life_rule_word(t, m, b, window[0] + window[1] + window[2],
                                             c > 0, '0, 1'b0);
               r.out_column = COL_OUT_W'(c);
               r.run_last   = 1'b1;
               pending_words = {pending_words, r};
            end
         end
         older_line[c]  = m;
         middle_line[c] = b;
         window[3] = window[0];
         window[4] = window[1];
         window[5] = window[2];
         window[0] = t;
         window[1] = m;
         window[2] = b;
         if (last) begin
            column_count = 0;
            if (row_count < 2) row_count++;
         end else begin
            column_count = c + 1;
         end
      endfunction

      function void check_next_word(input word_type w, input logic [COL_OUT_W-1:0] col,
                                    input logic lst);
         next_gen_type e;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected result next_word=%h out_column=%0d run_last=%0b",
                     $time, w, col, lst);
            errors++;
            return;
         end
         e = pending_words.pop_front();
         if (w !== e.next_word) begin
            $display("%0t: next_word expected %h actual %h", $time, e.next_word, w);
            errors++;
         end
         if (col !== e.out_column) begin
            $display("%0t: out_column expected %0d actual %0d", $time, e.out_column, col);
            errors++;
         end
         if (lst !== e.run_last) begin
            $display("%0t: run_last expected %0b actual %0b", $time, e.run_last, lst);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;
   bit               calm;
   int               rsp_stall;
   int unsigned      words_sent;

   life_step_scoreboard sb = new();

   plsw_req_if req_ch ();
   plsw_rsp_if rsp_ch ();

   packed_life_stencil_step_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stall after each transfer
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_next_word(rsp_ch.next_word, rsp_ch.out_column, rsp_ch.run_last);
         rsp_stall = calm ? 0 : $urandom_range(0, 3);
      end
   end

   task automatic send_cell_word(input word_type grid_word, input bit frame_start);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.cell_word   <= grid_word;
      req_ch.frame_start <= frame_start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.take_cell_word(grid_word, frame_start);
      words_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_words(input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.row_words = value;
   endtask

   function automatic word_type pick_cell_word();
      word_type raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return raw;
         1: return '0;
         2: return '1;
         3: return raw & {$urandom, $urandom} & NIBBLE_ONES;
         default: return raw & NIBBLE_ONES;
      endcase
   endfunction

   // mostly whole frames, rare restarts mid-frame and rare full drains
   task automatic send_frame(input int unsigned cols, input int unsigned rows);
      bit restart;
      for (int unsigned r = 0; r < rows; r++) begin
         for (int unsigned c = 0; c < cols; c++) begin
            restart = (r == 0 && c == 0) || ($urandom_range(0, 99) == 0);
            if ($urandom_range(0, 149) == 0) drain_results();
            send_cell_word(pick_cell_word(), restart);
         end
      end
   endtask

   initial begin
      word_type    frame3[11];
      int unsigned width;
      int unsigned rows;
      int unsigned phase;
      int          sel;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.cell_word   = '0;
      req_ch.frame_start = 1'b0;
      calm               = 1'b0;
      rsp_stall          = 0;
      words_sent         = 0;
      frame3 = '{64'h1000_0000_0000_0001, 64'h0001_1100_0000_1000, NIBBLE_ONES,
                 64'h0000_0000_0000_0001, 64'h1110_0000_0000_0111, 64'h1000_0000_0000_0000,
                 64'h1000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                 64'h0101_0101_0101_0101, 64'h1010_1010_1010_1010};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset width of one word: every word closes a row
      send_cell_word(NIBBLE_ONES, 1'b1);
      send_cell_word('1, 1'b0);
      send_cell_word('0, 1'b0);
      send_cell_word(64'h8000_0000_0000_0001, 1'b0);
      send_cell_word(NIBBLE_ONES, 1'b0);
      drain_results();

      // three-word rows, then stop mid-row and narrow the width
      write_row_words(CFG_W'(3));
      foreach (frame3[i]) send_cell_word(frame3[i], i == 0);
      drain_results();
      write_row_words(CFG_W'(1));
      send_cell_word(64'h1001_0110_1001_0110, 1'b0);
      send_cell_word(64'h0110_1001_0110_1001, 1'b0);

      phase = 0;
      while (words_sent < TOTAL_WORDS) begin
         calm = ($urandom_range(0, 4) == 0);
         sel  = $urandom_range(0, 39);
         if (phase == 0) width = 0;
         else if (phase == 1) width = 127;
         else begin
            case (sel)
               0:       width = 0;
               1:       width = 127;
               2:       width = $urandom_range(65, 126);
               3:       width = 64;
               4, 5, 6, 7, 8, 9, 10, 11: width = $urandom_range(7, 20);
               default: width = $urandom_range(1, 6);
            endcase
         end
         rows = (width > 20) ? 3 : $urandom_range(3, 6);
         drain_results();
         write_row_words(CFG_W'(width));
         send_frame((width == 0) ? 1 : ((width > MAX_WORDS) ? MAX_WORDS : width), rows);
         phase++;
      end

      calm = 1'b0;
      drain_results();
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
